[rtl/kst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants
// Widths, reset values and controller codes for the spanning tree block.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned MaxEdges    = 120;
  localparam int unsigned WeightBits  = 16;

  localparam int unsigned CfgDataBits  = 16;
  localparam int unsigned CountBits    = 5;
  localparam int unsigned VertexOutBits = 4;

  localparam logic [CountBits-1:0]   VertexCountReset = 5'd16;
  localparam logic [CfgDataBits-1:0] NoEdgeReset      = 16'd999;

  localparam logic RegVertexCount = 1'b0;
  localparam logic RegNoEdge      = 1'b1;

  typedef enum logic [3:0] {
    StLoad,
    StSortRd,
    StSortCmp,
    StUfInit,
    StEdgeRd,
    StFindA,
    StFindB,
    StJoin,
    StOut,
    StFinal,
    StClear
  } state_e;

  typedef struct packed {
    logic load_cell;
    logic sort_start;
    logic sort_rd;
    logic sort_cmp;
    logic uf_init;
    logic edge_rd;
    logic find_a;
    logic find_b;
    logic unite;
    logic clear;
  } ctrl_t;

  typedef struct packed {
    logic sort_done;
    logic find_done;
    logic roots_differ;
    logic edges_done;
    logic tree_full;
    logic none_taken;
  } stat_t;

endpackage
`default_nettype wire

[rtl/kruskal_spanning_tree_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kruskal_spanning_tree_core: minimum spanning forest of a streamed matrix
// Matrix cells are taken one a cycle. After the final cell an insertion sort
// over the edge memory alternates a read and a compare state, then
// union-find reads each edge, walks the parent table from both endpoints to
// their roots and joins the roots if they differ. Each accepted edge waits
// in a hold register until the next accepted edge or the end of the loop sets
// its last flag, then leaves through the output register. No new matrix is
// taken until the final word is loaded.
// ----------------------------------------------------------------------------
module kruskal_spanning_tree_core #(
  parameter int unsigned MAX_VERTICES = kst_pkg::MaxVertices,
  parameter int unsigned MAX_EDGES    = kst_pkg::MaxEdges
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // cell_weight
  input  wire logic        s_axis_tlast,   // matrix_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // from_vertex, to_vertex, edge_weight
  output logic             m_axis_tuser,   // tree_empty
  output logic             m_axis_tlast    // last_edge
);

  logic [kst_pkg::CountBits-1:0]   vcount_q;
  logic [kst_pkg::CfgDataBits-1:0] none_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= kst_pkg::VertexCountReset;
      none_q   <= kst_pkg::NoEdgeReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == kst_pkg::RegVertexCount)
        vcount_q <= cfg_data_i[kst_pkg::CountBits-1:0];
      else
        none_q <= cfg_data_i;
    end
  end

  kst_pkg::ctrl_t ctrl;
  kst_pkg::stat_t stat;
  logic push, push_empty;
  logic [3:0] from_v, to_v;
  logic [15:0] wt;

  kst_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i   (s_axis_tvalid && s_axis_tready),
    .in_last_i   (s_axis_tlast),
    .out_busy_i  (m_axis_tvalid && !m_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .in_ready_o  (s_axis_tready),
    .out_push_o  (push),
    .out_empty_o (push_empty)
  );

  kst_datapath #(
    .MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)
  ) u_dp (
    .clk_i, .rst_ni,
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .cell_i       (s_axis_tdata),
    .vcount_i     (vcount_q),
    .none_i       (none_q),
    .push_i       (push),
    .push_empty_i (push_empty),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_from_o   (from_v),
    .out_to_o     (to_v),
    .out_weight_o (wt),
    .out_empty_o  (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {wt, to_v, from_v};

endmodule
`default_nettype wire

[rtl/kst_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kst_ctrl: sequencer
// Steps the load, sort, union-find and output phases.
// ----------------------------------------------------------------------------
module kst_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_fire_i,
  input  wire logic          in_last_i,
  input  wire logic          out_busy_i,
  input  wire kst_pkg::stat_t stat_i,
  output kst_pkg::ctrl_t     ctrl_o,
  output logic               in_ready_o,
  output logic               out_push_o,
  output logic               out_empty_o
);

  kst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= kst_pkg::StLoad;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_push_o  = 1'b0;
    out_empty_o = 1'b0;
    case (state_q)
      kst_pkg::StLoad: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          ctrl_o.load_cell = 1'b1;
          if (in_last_i) begin
            ctrl_o.sort_start = 1'b1;
            state_d = kst_pkg::StSortRd;
          end
        end
      end
      kst_pkg::StSortRd: begin
        if (stat_i.sort_done) state_d = kst_pkg::StUfInit;
        else begin
          ctrl_o.sort_rd = 1'b1;
          state_d = kst_pkg::StSortCmp;
        end
      end
      kst_pkg::StSortCmp: begin
        ctrl_o.sort_cmp = 1'b1;
        state_d = kst_pkg::StSortRd;
      end
      kst_pkg::StUfInit: begin
        ctrl_o.uf_init = 1'b1;
        state_d = kst_pkg::StEdgeRd;
      end
      kst_pkg::StEdgeRd: begin
        if (stat_i.edges_done || stat_i.tree_full) begin
          state_d = kst_pkg::StFinal;
        end else begin
          ctrl_o.edge_rd = 1'b1;
          state_d = kst_pkg::StFindA;
        end
      end
      kst_pkg::StFindA: begin
        ctrl_o.find_a = 1'b1;
        if (stat_i.find_done) state_d = kst_pkg::StFindB;
      end
      kst_pkg::StFindB: begin
        ctrl_o.find_b = 1'b1;
        if (stat_i.find_done) state_d = kst_pkg::StJoin;
      end
      kst_pkg::StJoin: begin
        if (!stat_i.roots_differ) state_d = kst_pkg::StEdgeRd;
        else if (!out_busy_i) begin
          ctrl_o.unite = 1'b1;
          out_push_o   = 1'b1;
          state_d = kst_pkg::StEdgeRd;
        end
      end
      kst_pkg::StFinal: begin
        if (!out_busy_i) begin
          out_push_o  = 1'b1;
          out_empty_o = stat_i.none_taken;
          state_d = kst_pkg::StClear;
        end
      end
      kst_pkg::StClear: begin
        ctrl_o.clear = 1'b1;
        state_d = kst_pkg::StLoad;
      end
      default: state_d = kst_pkg::StLoad;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_busy_i)
    else $error("push into full output register");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == kst_pkg::StLoad)
    else $error("input ready outside load");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.unite |-> stat_i.roots_differ)
    else $error("join of one component");

endmodule
`default_nettype wire

[rtl/kst_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kst_datapath: edge store, insertion sort and union-find
// Holds the edge memory, parent table and output register.
// ----------------------------------------------------------------------------
module kst_datapath #(
  parameter int unsigned MAX_VERTICES = kst_pkg::MaxVertices,
  parameter int unsigned MAX_EDGES    = kst_pkg::MaxEdges
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire kst_pkg::ctrl_t                 ctrl_i,
  output kst_pkg::stat_t                      stat_o,
  input  wire logic [kst_pkg::WeightBits-1:0] cell_i,
  input  wire logic [kst_pkg::CountBits-1:0]  vcount_i,
  input  wire logic [kst_pkg::WeightBits-1:0] none_i,
  input  wire logic                           push_i,
  input  wire logic                           push_empty_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [kst_pkg::VertexOutBits-1:0]   out_from_o,
  output logic [kst_pkg::VertexOutBits-1:0]   out_to_o,
  output logic [kst_pkg::WeightBits-1:0]      out_weight_o,
  output logic                                out_empty_o,
  output logic                                out_last_o
);

  localparam int unsigned WEIGHT_BITS = kst_pkg::WeightBits;
  localparam int unsigned VB = $clog2(MAX_VERTICES);
  localparam int unsigned EB = $clog2(MAX_EDGES + 1);
  localparam int unsigned AB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned VCB = $clog2(MAX_VERTICES + 1);
  localparam int unsigned WW = 2 * VB + WEIGHT_BITS;
  localparam logic [EB-1:0] EdgeMax = EB'(MAX_EDGES);
  localparam logic [VCB-1:0] TreeMax = VCB'(MAX_VERTICES - 1);

  logic [WW-1:0] mem_q [MAX_EDGES];
  logic [WW-1:0] rd_q;
  logic [EB-1:0] total_q, i_q, j_q;
  logic [WW-1:0] key_q;
  logic [VB:0]   row_q, col_q;
  logic [VB-1:0] parent_q [MAX_VERTICES];
  logic [VB-1:0] walk_q, root_a_q, root_b_q;
  logic [VCB-1:0] taken_q;
  logic          ins_q;
  logic          walk_on_q;

  logic [VB:0] n_eff;
  always_comb begin
    n_eff = (VB + 1)'(MAX_VERTICES);
    if (vcount_i == '0) n_eff = (VB + 1)'(1);
    else if ({{(VB + 1){1'b0}}, vcount_i} < {{kst_pkg::CountBits{1'b0}}, n_eff})
      n_eff = (VB + 1)'(vcount_i);
  end

  logic keep;
  assign keep = ctrl_i.load_cell && (row_q < n_eff) && (col_q < n_eff) &&
                (col_q < row_q) && (cell_i != none_i) && (total_q < EdgeMax);

  // memory write and read address
  logic          wr_en;
  logic [AB-1:0] wr_addr, rd_addr;
  logic [WW-1:0] wr_data;
  logic [EB-1:0] jm1;
  assign jm1 = j_q - EB'(1);

  logic [WEIGHT_BITS-1:0] rd_w, key_w;
  assign rd_w  = rd_q[WEIGHT_BITS-1:0];
  assign key_w = key_q[WEIGHT_BITS-1:0];
  logic shift;
  assign shift = (j_q != '0) && ($signed(rd_w) > $signed(key_w));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AB'(total_q);
    wr_data = {row_q[VB-1:0], col_q[VB-1:0], cell_i};
    rd_addr = AB'(jm1);
    if (keep) wr_en = 1'b1;
    else if (ctrl_i.sort_cmp) begin
      wr_en = 1'b1;
      wr_addr = AB'(j_q);
      wr_data = shift ? rd_q : key_q;
    end
    if (ctrl_i.edge_rd) rd_addr = AB'(i_q);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (ctrl_i.sort_rd || ctrl_i.edge_rd) rd_q <= mem_q[rd_addr];
  end

  // key is the element being inserted; load it with the first compare read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0; row_q <= '0; col_q <= '0;
      i_q <= '0; j_q <= '0; ins_q <= 1'b0; taken_q <= '0;
      walk_on_q <= 1'b0;
    end else begin
      if (ctrl_i.load_cell && row_q < n_eff) begin
        if (keep) total_q <= total_q + EB'(1);
        if (col_q + (VB + 1)'(1) >= n_eff) begin
          col_q <= '0;
          row_q <= row_q + (VB + 1)'(1);
        end else col_q <= col_q + (VB + 1)'(1);
      end
      if (ctrl_i.sort_start) begin
        i_q <= EB'(1); j_q <= EB'(1); ins_q <= 1'b0;
      end
      if (ctrl_i.sort_rd) begin
        if (!ins_q) begin
          key_q <= mem_q[AB'(i_q)];
          ins_q <= 1'b1;
        end
      end
      if (ctrl_i.sort_cmp) begin
        if (shift) j_q <= jm1;
        else begin
          i_q <= i_q + EB'(1);
          j_q <= i_q + EB'(1);
          ins_q <= 1'b0;
        end
      end
      if (ctrl_i.uf_init) begin
        i_q <= '0; taken_q <= '0;
      end
      if (ctrl_i.edge_rd) i_q <= i_q + EB'(1);
      if (ctrl_i.unite) taken_q <= taken_q + VCB'(1);
      walk_on_q <= (ctrl_i.find_a || ctrl_i.find_b) && !stat_o.find_done;
      if (ctrl_i.clear) begin
        total_q <= '0; row_q <= '0; col_q <= '0;
      end
    end
  end

  // find: one parent hop a cycle; there is no path compression
  logic [VB-1:0] start_v, cur_v;
  assign start_v = ctrl_i.find_a ? rd_q[WW-1 -: VB] : rd_q[WW-VB-1 -: VB];
  assign cur_v   = walk_on_q ? walk_q : start_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_VERTICES; k++) parent_q[k] <= VB'(k);
    end else if (ctrl_i.uf_init || ctrl_i.clear) begin
      for (int k = 0; k < MAX_VERTICES; k++) parent_q[k] <= VB'(k);
    end else if (ctrl_i.unite) begin
      parent_q[root_b_q] <= root_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.find_a || ctrl_i.find_b) begin
      walk_q <= parent_q[cur_v];
      if (parent_q[cur_v] == cur_v) begin
        if (ctrl_i.find_a) root_a_q <= cur_v;
        else               root_b_q <= cur_v;
      end
    end
  end

  // sort loop ends after the last element when i reaches total
  assign stat_o.sort_done       = (i_q >= total_q);
  assign stat_o.find_done       = (parent_q[cur_v] == cur_v);
  assign stat_o.roots_differ    = (root_a_q != root_b_q);
  assign stat_o.edges_done      = (i_q >= total_q);
  assign stat_o.tree_full       = (taken_q >= TreeMax);
  assign stat_o.none_taken      = (taken_q == '0);

  // hold each accepted edge until the next one or the loop end decides its last flag
  logic          final_push;
  logic          load_out;
  logic [WW-1:0] hold_q;
  logic          hold_v_q;
  assign final_push = push_i && !ctrl_i.unite;
  assign load_out   = final_push || (ctrl_i.unite && hold_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      hold_v_q    <= 1'b0;
    end else begin
      if (load_out) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (ctrl_i.unite) hold_v_q <= 1'b1;
      else if (final_push || ctrl_i.clear) hold_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.unite) hold_q <= rd_q;
    if (load_out) begin
      out_from_o   <= kst_pkg::VertexOutBits'(push_empty_i ? '0 : hold_q[WW-1 -: VB]);
      out_to_o     <= kst_pkg::VertexOutBits'(push_empty_i ? '0 : hold_q[WW-VB-1 -: VB]);
      out_weight_o <= push_empty_i ? '0 : hold_q[WEIGHT_BITS-1:0];
      out_empty_o  <= push_empty_i;
      out_last_o   <= final_push;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.unite |-> !out_valid_o || out_ready_i)
    else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= EdgeMax)
    else $error("edge count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.sort_cmp |-> j_q <= i_q)
    else $error("insert position past key");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_push |-> (hold_v_q != push_empty_i))
    else $error("final word does not match held edge");

endmodule
`default_nettype wire
